// ----- hdl/threshold_trigger_delay_timer_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the threshold trigger delay timer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_TRIGGER_DELAY_TIMER_TOP_MACROS_SVH
`define THRESHOLD_TRIGGER_DELAY_TIMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define TTDT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define TTDT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TTDT_ASSERT_SAME(label, clk, rstn, ante, cons)
`define TTDT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/ttdt_pkg.sv -----
// ----------------------------------------------------------------------------
// ttdt_pkg
// Types and constants shared by the threshold trigger delay timer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ttdt_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int COUNT_W     = 16;
    localparam int HOLD_W      = 24;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [HOLD_W-1:0] HOLD_TICKS = 24'd4000000;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MODE    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LEVEL_A = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LEVEL_B = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_DELAY   = 4'd3;

    // Trigger modes.
    localparam logic [MODE_W-1:0] MODE_BOTH_FIRST  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BOTH_SECOND = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NONE        = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MEASURED    = 3'd4;

    // Reset values of the registers.
    localparam logic [MODE_W-1:0]     RESET_MODE    = MODE_BOTH_FIRST;
    localparam logic [SAMPLE_W-1:0]   RESET_LEVEL   = 10'd5;
    localparam logic [COUNT_W-1:0]    RESET_DELAY   = 16'd0;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_IDLE     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_WAITING  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_ACTIVE   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_DONE     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ALREADY  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_BAD_MODE = 3'd5;

    typedef struct packed {
        logic                arm;
        logic [SAMPLE_W-1:0] sample_a;
        logic [SAMPLE_W-1:0] sample_b;
    } in_word_t;

    typedef struct packed {
        logic                out_immediate;
        logic                out_delayed;
        logic                arm_lamp;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  measured_count;
        logic [COUNT_W-1:0]  compare_count;
    } out_word_t;

    typedef struct packed {
        logic [MODE_W-1:0]   trigger_mode;
        logic [SAMPLE_W-1:0] level_a;
        logic [SAMPLE_W-1:0] level_b;
        logic [COUNT_W-1:0]  added_delay;
    } cfg_regs_t;

endpackage

`default_nettype wire

// ----- hdl/ttdt_cfg.sv -----
// ----------------------------------------------------------------------------
// ttdt_cfg
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ttdt_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_write,
    input  wire logic [ttdt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ttdt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ttdt_pkg::cfg_regs_t                    regs
);
    import ttdt_pkg::*;

    cfg_regs_t regs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.trigger_mode <= RESET_MODE;
            regs_reg.level_a      <= RESET_LEVEL;
            regs_reg.level_b      <= RESET_LEVEL;
            regs_reg.added_delay  <= RESET_DELAY;
        end else if (cfg_write) begin
            // Writes to indexes beyond the register list are dropped.
            case (cfg_index)
                CFG_IDX_MODE:    regs_reg.trigger_mode <= cfg_data[MODE_W-1:0];
                CFG_IDX_LEVEL_A: regs_reg.level_a      <= cfg_data[SAMPLE_W-1:0];
                CFG_IDX_LEVEL_B: regs_reg.level_b      <= cfg_data[SAMPLE_W-1:0];
                CFG_IDX_DELAY:   regs_reg.added_delay  <= cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

// ----- hdl/ttdt_core.sv -----
// ----------------------------------------------------------------------------
// ttdt_core
// Run state machine, interval counter and hold timer; one tick per step.
// ----------------------------------------------------------------------------
`default_nettype none

module ttdt_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  ttdt_pkg::in_word_t        word,
    input  ttdt_pkg::cfg_regs_t       regs,
    output ttdt_pkg::out_word_t       result
);
    import ttdt_pkg::*;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_WAIT_BOTH = 3'd1;
    localparam logic [2:0] PH_WAIT_A4   = 3'd2;
    localparam logic [2:0] PH_TIMING    = 3'd3;
    localparam logic [2:0] PH_DELAY     = 3'd4;
    localparam logic [2:0] PH_HOLD      = 3'd5;

    logic [2:0]         phase_reg, phase_next;
    logic [COUNT_W-1:0] tick_count_reg, tick_count_next;
    logic [COUNT_W-1:0] capture_reg, capture_next;
    logic [COUNT_W-1:0] fire_at_reg, fire_at_next;
    logic [HOLD_W-1:0]  hold_left_reg, hold_left_next;
    logic               imm_reg, imm_next;
    logic               del_reg, del_next;

    logic               ev_a, ev_b;
    logic [COUNT_W-1:0] tick_inc;
    logic [COUNT_W-1:0] fire_calc;
    logic [STATUS_W-1:0] status;

    assign ev_a      = word.sample_a > regs.level_a;
    assign ev_b      = word.sample_b > regs.level_b;
    assign tick_inc  = tick_count_reg + COUNT_W'(1);
    // Twice the interval plus the extra delay, wrapping in 16 bits.
    assign fire_calc = {tick_inc[COUNT_W-2:0], 1'b0} + regs.added_delay;

    always_comb begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        capture_next    = capture_reg;
        fire_at_next    = fire_at_reg;
        hold_left_next  = hold_left_reg;
        imm_next        = imm_reg;
        del_next        = del_reg;
        status          = STATUS_IDLE;

        case (phase_reg)
            PH_WAIT_BOTH: begin
                if (ev_a) begin
                    imm_next       = 1'b1;
                    del_next       = 1'b1;
                    hold_left_next = HOLD_TICKS;
                    phase_next     = PH_HOLD;
                end
            end
            PH_WAIT_A4: begin
                if (ev_a) begin
                    imm_next        = 1'b1;
                    tick_count_next = '0;
                    phase_next      = PH_TIMING;
                end
            end
            PH_TIMING: begin
                tick_count_next = tick_inc;
                if (ev_b) begin
                    capture_next = tick_inc;
                    fire_at_next = fire_calc;
                    phase_next   = PH_DELAY;
                    // The match can already occur on the event B tick.
                    if (tick_inc == fire_calc) begin
                        del_next       = 1'b1;
                        hold_left_next = HOLD_TICKS;
                        phase_next     = PH_HOLD;
                    end
                end
            end
            PH_DELAY: begin
                tick_count_next = tick_inc;
                if (tick_inc == fire_at_reg) begin
                    del_next       = 1'b1;
                    hold_left_next = HOLD_TICKS;
                    phase_next     = PH_HOLD;
                end
            end
            PH_HOLD: begin
                if (hold_left_reg <= HOLD_W'(1)) begin
                    hold_left_next = '0;
                    imm_next       = 1'b0;
                    del_next       = 1'b0;
                    phase_next     = PH_IDLE;
                    status         = STATUS_DONE;
                end else begin
                    hold_left_next = hold_left_reg - HOLD_W'(1);
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (word.arm) begin
                    if (regs.trigger_mode < MODE_BOTH_FIRST ||
                        regs.trigger_mode > MODE_MEASURED) begin
                        status = STATUS_BAD_MODE;
                    end else if (ev_a) begin
                        status = STATUS_ALREADY;
                    end else if (regs.trigger_mode == MODE_NONE) begin
                        status = STATUS_DONE;
                    end else if (regs.trigger_mode == MODE_MEASURED) begin
                        phase_next = PH_WAIT_A4;
                    end else begin
                        phase_next = PH_WAIT_BOTH;
                    end
                end
            end
        endcase

        if (phase_next == PH_WAIT_BOTH || phase_next == PH_WAIT_A4) begin
            status = STATUS_WAITING;
        end else if (phase_next == PH_TIMING || phase_next == PH_DELAY ||
                     phase_next == PH_HOLD) begin
            status = STATUS_ACTIVE;
        end

        result.out_immediate  = imm_next;
        result.out_delayed    = del_next;
        result.arm_lamp       = phase_next != PH_IDLE;
        result.status         = status;
        result.measured_count = capture_next;
        result.compare_count  = fire_at_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            capture_reg    <= '0;
            fire_at_reg    <= '0;
            hold_left_reg  <= '0;
            imm_reg        <= 1'b0;
            del_reg        <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            capture_reg    <= capture_next;
            fire_at_reg    <= fire_at_next;
            hold_left_reg  <= hold_left_next;
            imm_reg        <= imm_next;
            del_reg        <= del_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/threshold_trigger_delay_timer_top.sv -----
// ----------------------------------------------------------------------------
// threshold_trigger_delay_timer_top
// Threshold trigger with immediate and measured-delay outputs and hold timer.
// ----------------------------------------------------------------------------
`default_nettype none

// Each input word is one timer tick and yields exactly one result word. A
// word is registered on acceptance and is evaluated, once the output
// register can take its result, by a single pass through the run state
// machine, whose result lands in the output register; m_valid rises when
// it is registered, and one word is taken per cycle while results are taken.
// The input and output registers form a two-word pipeline: when the result
// channel stalls while the input register holds a word, s_ready drops in the
// same cycle, and an empty input register takes one more word before the
// input stalls. Configuration writes are always ready and should be issued
// only while no word is in flight.

`include "threshold_trigger_delay_timer_top_macros.svh"

module threshold_trigger_delay_timer_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output wire logic                              s_ready,
    input  ttdt_pkg::in_word_t                     s_data,
    output wire logic                              m_valid,
    input  wire logic                              m_ready,
    output ttdt_pkg::out_word_t                    m_data,
    input  wire logic                              cfg_valid,
    output wire logic                              cfg_ready,
    input  wire logic [ttdt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ttdt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ttdt_pkg::*;

    in_word_t  in_word_reg;
    logic      in_valid_reg;
    out_word_t out_word_reg;
    logic      out_valid_reg;

    cfg_regs_t regs;
    out_word_t step_result;
    logic      advance;
    logic      step;

    assign advance   = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_word_reg;

    ttdt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    ttdt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .word    (in_word_reg),
        .regs    (regs),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_word_reg <= step_result;
        end
    end

    // Outputs are only ever latched during a run.
    `TTDT_ASSERT_SAME(a_outputs_need_run, aclk, aresetn,
        m_valid && !m_data.arm_lamp,
        !m_data.out_immediate && !m_data.out_delayed)
    // While waiting for event A neither output has been raised.
    `TTDT_ASSERT_SAME(a_waiting_outputs_low, aclk, aresetn,
        m_valid && m_data.status == STATUS_WAITING,
        m_data.arm_lamp && !m_data.out_immediate && !m_data.out_delayed)
    // Without a run the status is never waiting or active.
    `TTDT_ASSERT_SAME(a_idle_status, aclk, aresetn,
        m_valid && !m_data.arm_lamp,
        m_data.status != STATUS_WAITING && m_data.status != STATUS_ACTIVE)
    // Every evaluated word shows up in the output register.
    `TTDT_ASSERT_NEXT(a_step_reaches_output, aclk, aresetn,
        step,
        out_valid_reg)

endmodule

`default_nettype wire
